@@ rtl/scr_pkg.sv @@
// Shared types, register codes and helpers for the scanline coverage resolver.
`default_nettype none

package scr_pkg;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_ROW_WIDTH    = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_COV_SCALE    = 2'd2;
    localparam logic [1:0] REG_RESOLVE_MODE = 2'd3;

    // Fill rule codes; the unused code behaves as nonzero.
    localparam logic [1:0] MODE_DIRECT  = 2'd0;
    localparam logic [1:0] MODE_NONZERO = 2'd1;
    localparam logic [1:0] MODE_EVENODD = 2'd2;

    // Field widths.
    localparam int DIM_W   = 13;
    localparam int SCALE_W = 31;
    localparam int SUM_W   = 32;
    localparam int MODE_W  = 2;

    // Size arithmetic is done at 17 bits, enough for a limit of 65536.
    localparam int SIZE_W = 17;

    // Queue between the accumulator and the resolve unit.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One accumulated cell waiting to be resolved.
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic             row_end;
        logic             frame_end;
    } scr_entry_t;

    // Zero counts as one, anything above the limit saturates to the limit.
    function automatic logic [SIZE_W-1:0] eff_size(
        input logic [DIM_W-1:0]  v,
        input logic [SIZE_W-1:0] limit
    );
        logic [SIZE_W-1:0] ext;
        ext = SIZE_W'(v);
        if (ext == '0)
        begin
            return SIZE_W'(1);
        end
        else if (ext > limit)
        begin
            return limit;
        end
        return ext;
    endfunction

endpackage

`default_nettype wire

@@ rtl/scanline_coverage_resolve.sv @@
// Top level: configuration registers, front end, queue and resolve unit.
//
//   Channel   Direction  Handshake             Word
//   input     in         in_valid / in_ready   delta (32-bit signed)
//   output    out        out_valid / out_ready coverage, last_in_row, last_in_frame
//   config    in         APB psel/penable      row_width, frame_height,
//                                              coverage_scale, resolve_mode
//
// The front end takes one delta word per cycle while the two-entry queue has room.
// The resolve unit takes a new word only after the last one is loaded into the output register.
// In even-odd mode with a nonzero scale a bit-serial remainder runs 32 steps first; other modes skip it.
// Reset clears the row sum, the position counters, the queue and the output valid flag;
// no clearing pass follows. Either side may stall; the queue and output register
// absorb the difference.
`default_nettype none

module scanline_coverage_resolve #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [3:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    input  wire logic signed [31:0]            delta,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    output logic [30:0]                        coverage,
    output logic                               last_in_row,
    output logic                               last_in_frame,
    output logic                               out_valid,
    input  wire logic                          out_ready
);
    import scr_pkg::*;

    logic [DIM_W-1:0]   row_width_reg;
    logic [DIM_W-1:0]   frame_height_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic [MODE_W-1:0]  mode_reg;
    logic               cfg_write;

    logic               q_full;
    logic               q_push;
    logic               q_pop;
    logic               q_not_empty;
    scr_entry_t         q_entry;
    scr_entry_t         q_head;

    // Register port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg    <= DIM_W'(1);
            frame_height_reg <= DIM_W'(1);
            scale_reg        <= SCALE_W'(131072);
            mode_reg         <= MODE_NONZERO;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_ROW_WIDTH:    row_width_reg    <= pwdata[DIM_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= pwdata[DIM_W-1:0];
                REG_COV_SCALE:    scale_reg        <= pwdata[SCALE_W-1:0];
                REG_RESOLVE_MODE: mode_reg         <= pwdata[MODE_W-1:0];
                default:          mode_reg         <= mode_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_ROW_WIDTH:    prdata = 32'(row_width_reg);
            REG_FRAME_HEIGHT: prdata = 32'(frame_height_reg);
            REG_COV_SCALE:    prdata = 32'(scale_reg);
            REG_RESOLVE_MODE: prdata = 32'(mode_reg);
            default:          prdata = '0;
        endcase
    end

    // Accumulator and position tracking.
    scr_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .delta        (delta),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .row_width    (row_width_reg),
        .frame_height (frame_height_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_entry      (q_entry)
    );

    // Decoupling queue.
    scr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .full       (q_full),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    // Fill rule resolution and output register.
    scr_resolve u_resolve (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_not_empty    (q_not_empty),
        .q_head         (q_head),
        .q_pop          (q_pop),
        .coverage_scale (scale_reg),
        .resolve_mode   (mode_reg),
        .coverage       (coverage),
        .last_in_row    (last_in_row),
        .last_in_frame  (last_in_frame),
        .out_valid      (out_valid),
        .out_ready      (out_ready)
    );

endmodule

`default_nettype wire

@@ rtl/scr_front.sv @@
// Front end: accepts delta words, keeps the row sum and the raster position.
`default_nettype none

module scr_front #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [scr_pkg::SUM_W-1:0]   delta,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [scr_pkg::DIM_W-1:0]   row_width,
    input  wire logic [scr_pkg::DIM_W-1:0]   frame_height,
    input  wire logic                        q_full,
    output logic                             q_push,
    output scr_pkg::scr_entry_t              q_entry
);
    import scr_pkg::*;

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [SIZE_W-1:0] width_m1;
    logic [SIZE_W-1:0] height_m1;
    logic [SUM_W-1:0]  sum_new;
    logic              row_end;
    logic              frame_end;

    // Last column and last row of the frame as configured.
    assign width_m1  = eff_size(row_width, SIZE_W'(MAX_WIDTH)) - SIZE_W'(1);
    assign height_m1 = eff_size(frame_height, SIZE_W'(MAX_HEIGHT)) - SIZE_W'(1);

    // Accumulate and classify the incoming word.
    assign sum_new   = sum_reg + delta;
    assign row_end   = SIZE_W'(col_reg) >= width_m1;
    assign frame_end = row_end && (SIZE_W'(row_reg) >= height_m1);

    assign in_ready          = !q_full;
    assign q_push            = in_valid && !q_full;
    assign q_entry.sum       = sum_new;
    assign q_entry.row_end   = row_end;
    assign q_entry.frame_end = frame_end;

    // Position and sum update for an accepted word.
    always_comb
    begin
        sum_next = sum_reg;
        col_next = col_reg;
        row_next = row_reg;
        if (q_push)
        begin
            if (row_end)
            begin
                sum_next = '0;
                col_next = '0;
                row_next = frame_end ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                sum_next = sum_new;
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/scr_queue.sv @@
// Short first-in first-out queue between the front end and the resolve unit.
`default_nettype none

module scr_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire scr_pkg::scr_entry_t push_entry,
    input  wire logic                pop,
    output logic                     full,
    output logic                     not_empty,
    output scr_pkg::scr_entry_t      head
);
    import scr_pkg::*;

    scr_entry_t        mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full      = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign head      = mem_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

@@ rtl/scr_resolve.sv @@
// Back end: resolves a row sum by the fill rule and holds the output word.
`default_nettype none

module scr_resolve (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_not_empty,
    input  wire scr_pkg::scr_entry_t           q_head,
    output logic                               q_pop,
    input  wire logic [scr_pkg::SCALE_W-1:0]   coverage_scale,
    input  wire logic [scr_pkg::MODE_W-1:0]    resolve_mode,
    output logic [scr_pkg::SCALE_W-1:0]        coverage,
    output logic                               last_in_row,
    output logic                               last_in_frame,
    output logic                               out_valid,
    input  wire logic                          out_ready
);
    import scr_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam int STEP_W = $clog2(SUM_W);

    logic [1:0]         state_reg, state_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [SUM_W-1:0]   val_reg, val_next;
    logic [SUM_W-1:0]   quot_reg, quot_next;
    logic               row_end_reg, row_end_next;
    logic               frame_end_reg, frame_end_next;
    logic               out_valid_reg, out_valid_next;
    logic [SCALE_W-1:0] cov_reg, cov_next;
    logic               lir_reg, lir_next;
    logic               lif_reg, lif_next;

    logic [SUM_W-1:0]   period;
    logic [SUM_W-1:0]   scale_ext;
    logic               negative;
    logic [SUM_W-1:0]   magnitude;
    logic [SUM_W:0]     shifted;
    logic [SUM_W-1:0]   folded;
    logic [SCALE_W-1:0] capped;
    logic               load_out;

    assign period    = {coverage_scale, 1'b0};
    assign scale_ext = SUM_W'(coverage_scale);
    assign negative  = q_head.sum[SUM_W-1];
    assign magnitude = negative ? (~q_head.sum + SUM_W'(1)) : q_head.sum;

    // One restoring remainder step: bring in the next dividend bit.
    assign shifted = {val_reg, quot_reg[SUM_W-1]};

    // Fold back above the scale in even-odd mode, then cap at the scale.
    assign folded = ((resolve_mode == MODE_EVENODD) && (val_reg > scale_ext))
                    ? period - val_reg : val_reg;
    assign capped = (folded > scale_ext) ? coverage_scale : folded[SCALE_W-1:0];

    assign q_pop    = (state_reg == ST_IDLE) && q_not_empty;
    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    // Sequencer for one queued sum.
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        val_next       = val_reg;
        quot_next      = quot_reg;
        row_end_next   = row_end_reg;
        frame_end_next = frame_end_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_pop)
                begin
                    row_end_next   = q_head.row_end;
                    frame_end_next = q_head.frame_end;
                    step_next      = '0;
                    quot_next      = magnitude;
                    state_next     = ST_DONE;
                    if (resolve_mode == MODE_DIRECT)
                    begin
                        val_next = negative ? '0 : q_head.sum;
                    end
                    else if (resolve_mode == MODE_EVENODD)
                    begin
                        val_next = '0;
                        if (coverage_scale != '0)
                        begin
                            state_next = ST_DIV;
                        end
                    end
                    else
                    begin
                        val_next = magnitude;
                    end
                end
            end
            ST_DIV:
            begin
                if (shifted >= {1'b0, period})
                begin
                    val_next = SUM_W'(shifted - {1'b0, period});
                end
                else
                begin
                    val_next = shifted[SUM_W-1:0];
                end
                quot_next = {quot_reg[SUM_W-2:0], 1'b0};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(SUM_W - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output word register.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        cov_next       = cov_reg;
        lir_next       = lir_reg;
        lif_next       = lif_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            cov_next       = capped;
            lir_next       = row_end_reg;
            lif_next       = frame_end_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg       <= val_next;
        quot_reg      <= quot_next;
        row_end_reg   <= row_end_next;
        frame_end_reg <= frame_end_next;
        cov_reg       <= cov_next;
        lir_reg       <= lir_next;
        lif_reg       <= lif_next;
    end

    assign coverage      = cov_reg;
    assign last_in_row   = lir_reg;
    assign last_in_frame = lif_reg;
    assign out_valid     = out_valid_reg;

endmodule

`default_nettype wire

@@ sim/scanline_coverage_resolve_test.sv @@
// Testbench for the scanline coverage resolver: directed and random rows checked against a predictor.
`timescale 1ns / 1ps

module scanline_coverage_resolve_test;
    import scr_pkg::*;

    // The spare fill rule code, which behaves as nonzero.
    localparam logic [1:0] MODE_SPARE = 2'd3;

    localparam int unsigned ROW_LIMIT    = 4096;
    localparam int unsigned FRAME_LIMIT  = 4096;
    localparam int          SETTLE_CYCLES = 48;
    localparam int          LIMIT_CYCLES  = 600000;
    localparam int          RANDOM_CELLS  = 880;

    // One resolved word as the output channel should present it.
    typedef struct {
        logic [30:0] coverage;
        logic        row_end;
        logic        frame_end;
    } cell_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [3:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic signed [31:0] delta = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [30:0]        coverage;
    logic               last_in_row;
    logic               last_in_frame;
    logic               out_valid;
    logic               out_ready = 1'b0;

    // Predictor copy of the registers and the raster position.
    logic [12:0]  cfg_row_width = 13'd1;
    logic [12:0]  cfg_frame_height = 13'd1;
    logic [30:0]  cfg_scale = 31'd131072;
    logic [1:0]   cfg_mode = MODE_NONZERO;
    logic [31:0]  row_sum = '0;
    int unsigned  column_pos = 0;
    int unsigned  row_pos = 0;

    cell_result_t pending_cells[$];

    bit idle_on = 1'b0;
    int hold_request = 0;
    int stall_left = 0;
    int fail_count = 0;
    int cells_sent = 0;
    int results_checked = 0;
    int settings_count = 0;
    int cycle_count = 0;

    scanline_coverage_resolve u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .delta         (delta),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .coverage      (coverage),
        .last_in_row   (last_in_row),
        .last_in_frame (last_in_frame),
        .out_valid     (out_valid),
        .out_ready     (out_ready)
    );

    initial
    begin
        forever
        begin
            #1 clk = ~clk;
        end
    end

    // Give up when the run takes far longer than the slowest correct run.
    initial
    begin : watchdog
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    // A size register of zero means one, and sizes above the limit saturate.
    function automatic int unsigned clamp_size(input logic [12:0] v, input int unsigned limit);
        if (v == '0)
        begin
            return 1;
        end
        return (v > limit) ? limit : int'(v);
    endfunction

    // Resolve one running sum by the current fill rule.
    function automatic logic [30:0] resolve_coverage(input logic [31:0] sum);
        logic [63:0] scale_ext;
        logic [63:0] magnitude;
        logic [63:0] period;
        scale_ext = {33'b0, cfg_scale};
        if (cfg_mode == MODE_DIRECT)
        begin
            if (sum[31])
            begin
                return '0;
            end
            return ({32'b0, sum} > scale_ext) ? cfg_scale : sum[30:0];
        end
        magnitude = sum[31] ? (64'h1_0000_0000 - {32'b0, sum}) : {32'b0, sum};
        if (cfg_mode == MODE_EVENODD)
        begin
            period = scale_ext * 2;
            if (period == 0)
            begin
                return '0;
            end
            magnitude = magnitude % period;
            if (magnitude > scale_ext)
            begin
                magnitude = period - magnitude;
            end
        end
        return (magnitude > scale_ext) ? cfg_scale : magnitude[30:0];
    endfunction

    // Advance the predictor by one accepted delta word and queue its result.
    task automatic predict_cell(input logic [31:0] d);
        int unsigned  width;
        int unsigned  height;
        logic [31:0]  sum;
        cell_result_t res;
        width = clamp_size(cfg_row_width, ROW_LIMIT);
        height = clamp_size(cfg_frame_height, FRAME_LIMIT);
        sum = row_sum + d;
        res.row_end = (column_pos >= width - 1);
        res.frame_end = res.row_end && (row_pos >= height - 1);
        res.coverage = resolve_coverage(sum);
        pending_cells.insert(pending_cells.size(), res);
        if (res.row_end)
        begin
            row_sum = '0;
            column_pos = 0;
            row_pos = res.frame_end ? 0 : row_pos + 1;
        end
        else
        begin
            row_sum = sum;
            column_pos++;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("mismatch at result %0d: %s expected %0d, got %0d",
                 results_checked, what, want, got);
        fail_count++;
    endtask

    // Check every accepted result word against the oldest prediction.
    always @(posedge clk)
    begin : result_check
        cell_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_cells.size() == 0)
            begin
                report_mismatch("unexpected word, pending", 32'd0, 32'd1);
            end
            else
            begin
                want = pending_cells.pop_front();
                if (coverage !== want.coverage)
                    report_mismatch("coverage", 32'(want.coverage), 32'(coverage));
                if (last_in_row !== want.row_end)
                    report_mismatch("last_in_row", 32'(want.row_end), 32'(last_in_row));
                if (last_in_frame !== want.frame_end)
                    report_mismatch("last_in_frame", 32'(want.frame_end),
                                    32'(last_in_frame));
            end
            results_checked++;
        end
    end

    // The receiver: a long hold-off when asked, otherwise random stall bursts while idling is on.
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            out_ready <= 1'b0;
            hold_request--;
        end
        else if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            out_ready <= 1'b0;
            stall_left = $urandom_range(0, 16);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Write one register through a setup and an access phase.
    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_ROW_WIDTH:    cfg_row_width = value[12:0];
            REG_FRAME_HEIGHT: cfg_frame_height = value[12:0];
            REG_COV_SCALE:    cfg_scale = value[30:0];
            REG_RESOLVE_MODE: cfg_mode = value[1:0];
            default: ;
        endcase
    endtask

    task automatic write_setting(input logic [12:0] width, input logic [12:0] height,
                                 input logic [30:0] scale, input logic [1:0] mode);
        write_register(REG_ROW_WIDTH, {19'b0, width});
        write_register(REG_FRAME_HEIGHT, {19'b0, height});
        write_register(REG_COV_SCALE, {1'b0, scale});
        write_register(REG_RESOLVE_MODE, {30'b0, mode});
        settings_count++;
    endtask

    // Offer one delta word, after an occasional random gap, and hold it until accepted.
    task automatic send_delta(input logic [31:0] d);
        int gap;
        gap = (idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 17) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        delta <= d;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        predict_cell(d);
        cells_sent++;
    endtask

    // Called in the step of the last acceptance of a burst.
    task automatic release_input();
        in_valid <= 1'b0;
    endtask

    // The sender pauses until every predicted word has come back.
    task automatic wait_for_results();
        while (pending_cells.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [12:0] pick_size(input bit for_rows);
        case ($urandom_range(0, 15))
            0:       return 13'd0;
            1:       return 13'd4096;
            2:       return 13'h1FFF;
            3:       return 13'($urandom_range(4097, 8191));
            4:       return 13'($urandom_range(13, 300));
            default: return for_rows ? 13'($urandom_range(1, 12)) : 13'($urandom_range(1, 5));
        endcase
    endfunction

    function automatic logic [30:0] pick_scale();
        case ($urandom_range(0, 9))
            0:       return 31'd0;
            1:       return 31'd1;
            2:       return 31'h7FFF_FFFF;
            3:       return 31'($urandom);
            4:       return 31'd131072;
            default: return 31'($urandom_range(2, 5000));
        endcase
    endfunction

    // Mostly edge crossings and partial coverage around the scale, some raw noise.
    function automatic logic [31:0] pick_delta();
        longint span;
        longint v;
        span = (cfg_scale > (1 << 20)) ? (1 << 20) : longint'(cfg_scale);
        if (span == 0)
            span = 16;
        case ($urandom_range(0, 9))
            0: v = longint'($urandom);
            1:
            begin
                case ($urandom_range(0, 3))
                    0:       v = 32'h8000_0000;
                    1:       v = 32'h7FFF_FFFF;
                    2:       v = 0;
                    default: v = -1;
                endcase
            end
            2: v = longint'(cfg_scale);
            3: v = -longint'(cfg_scale);
            4: v = longint'($urandom_range(0, 6 * span)) - 3 * span;
            default: v = longint'($urandom_range(0, 2 * span)) - span;
        endcase
        return v[31:0];
    endfunction

    // Reset settings: single-cell rows, nonzero rule, and the delta extremes.
    task automatic test_reset_state();
        send_delta(32'd0);
        send_delta(32'hFFFF_FFFF);
        send_delta(32'h7FFF_FFFF);
        send_delta(32'h8000_0000);
        send_delta(32'd131073);
        send_delta(-32'sd131073);
        release_input();
        wait_for_results();
    endtask

    // Direct rule: negative sums give zero, large sums clamp, rows and frames end.
    task automatic test_direct_clamp();
        write_setting(13'd3, 13'd2, 31'd1000, MODE_DIRECT);
        send_delta(32'd600);
        send_delta(32'd600);
        send_delta(-32'sd5000);
        send_delta(32'h7FFF_FFFF);
        send_delta(32'd1);
        send_delta(32'd5);
        release_input();
        wait_for_results();
    endtask

    // Even-odd rule: folding past the scale, the most negative sum, widest and zero scale.
    task automatic test_evenodd_fold();
        write_setting(13'd4, 13'd1, 31'd100, MODE_EVENODD);
        send_delta(32'd150);
        send_delta(32'd100);
        send_delta(-32'sd400);
        send_delta(32'h8000_0000);
        release_input();
        wait_for_results();
        write_setting(13'd1, 13'd1, 31'h7FFF_FFFF, MODE_EVENODD);
        send_delta(32'h8000_0000);
        send_delta(32'h7FFF_FFFF);
        release_input();
        wait_for_results();
        write_register(REG_COV_SCALE, 32'd0);
        send_delta(32'd77);
        release_input();
        wait_for_results();
    endtask

    // Zero sizes, saturated sizes, the spare rule code and size changes mid-frame.
    task automatic test_odd_settings();
        write_setting(13'd0, 13'd0, 31'd0, MODE_SPARE);
        send_delta(32'd9);
        send_delta(-32'sd9);
        release_input();
        wait_for_results();
        write_setting(13'h1FFF, 13'h1FFF, 31'd1, MODE_SPARE);
        send_delta(32'd3);
        send_delta(-32'sd7);
        release_input();
        wait_for_results();
        // The position is past the new last column, so the next word ends its row.
        write_register(REG_ROW_WIDTH, 32'd2);
        send_delta(32'd1);
        release_input();
        wait_for_results();
        write_register(REG_FRAME_HEIGHT, 32'd1);
        send_delta(32'd1);
        send_delta(32'd1);
        release_input();
        wait_for_results();
    endtask

    // The receiver holds off long enough to fill the block and stall its input.
    task automatic test_output_backpressure();
        write_setting(13'd5, 13'd3, 31'd4096, MODE_NONZERO);
        idle_on = 1'b0;
        hold_request = 400;
        repeat (30) send_delta(pick_delta());
        release_input();
        wait_for_results();
    endtask

    // Random settings, each followed by a burst of delta words; the last stretch runs flat out.
    task automatic test_random_frames(input int target);
        int phase_items;
        int sent_here;
        sent_here = 0;
        while (sent_here < target)
        begin
            wait_for_results();
            write_setting(pick_size(1'b1), pick_size(1'b0), pick_scale(),
                          2'($urandom_range(0, 3)));
            idle_on = (target - sent_here > 150) && ($urandom_range(0, 3) != 0);
            phase_items = (clamp_size(cfg_row_width, ROW_LIMIT) >= 256) ?
                          10 : $urandom_range(15, 45);
            repeat (phase_items)
            begin
                send_delta(pick_delta());
                sent_here++;
            end
            release_input();
        end
        wait_for_results();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        idle_on = 1'b1;
        test_reset_state();
        test_direct_clamp();
        test_evenodd_fold();
        test_odd_settings();
        test_output_backpressure();
        test_random_frames(RANDOM_CELLS);
        $display("Sent %0d delta words and checked %0d results over %0d register settings,",
                 cells_sent, results_checked, settings_count);
        $display("covering all four rule codes, size and scale extremes and a long output stall.");
        if (fail_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ scanline_coverage_resolve.f @@
rtl/scr_pkg.sv
rtl/scr_front.sv
rtl/scr_queue.sv
rtl/scr_resolve.sv
rtl/scanline_coverage_resolve.sv
sim/scanline_coverage_resolve_test.sv
